/* design/piac_pkg.sv */
// ----------------------------------------------------------------------------
// Path-in-area check package
// Shared field widths, parameter defaults, codes and the table request type.
// ----------------------------------------------------------------------------
package piac_pkg;

  localparam int MAX_DIMS_DEF   = 16;
  localparam int MAX_ELEMS_DEF  = 1024;
  localparam int MAX_BORDER_DEF = 256;

  localparam int FUNC_W = 2;
  localparam int DIM_W  = 4;
  localparam int ID_W   = 10;
  localparam int TYPE_W = 2;
  localparam int SLOT_W = 8;
  localparam int CNT_W  = 9;
  localparam int TOT_W  = 11;

  localparam logic [TYPE_W-1:0] TYPE_CONS = 2'd1;

  typedef enum logic [FUNC_W-1:0] {
    FN_SET_TYPE   = 2'd0,
    FN_SET_BORDER = 2'd1,
    FN_SET_COUNT  = 2'd2,
    FN_QUERY      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TYPE,
    ST_COUNT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic et_we;
    logic et_re;
    logic bd_we;
    logic bd_re;
    logic cl_we;
    logic cl_re;
  } tbl_req_t;

endpackage

/* design/piac_tables.sv */
// ----------------------------------------------------------------------------
// Path-in-area check tables
// Element-type memory, border id memory and the per-list count and total
// memory with reset-cleared valid bits. All reads are registered.
// ----------------------------------------------------------------------------
module piac_tables #(
  parameter int MAX_DIMS   = piac_pkg::MAX_DIMS_DEF,
  parameter int MAX_ELEMS  = piac_pkg::MAX_ELEMS_DEF,
  parameter int MAX_BORDER = piac_pkg::MAX_BORDER_DEF,
  localparam int ET_DEPTH  = MAX_DIMS * MAX_ELEMS,
  localparam int ET_AW     = $clog2(ET_DEPTH),
  localparam int BD_DEPTH  = MAX_DIMS * 2 * MAX_BORDER,
  localparam int BD_AW     = $clog2(BD_DEPTH),
  localparam int CL_DEPTH  = MAX_DIMS * 2,
  localparam int CL_AW     = $clog2(CL_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  piac_pkg::tbl_req_t               req,
  input  logic [ET_AW-1:0]                 et_addr,
  input  logic [piac_pkg::TYPE_W-1:0]      et_wdata,
  output logic [piac_pkg::TYPE_W-1:0]      et_rdata,
  input  logic [BD_AW-1:0]                 bd_addr,
  input  logic [piac_pkg::ID_W-1:0]        bd_wdata,
  output logic [piac_pkg::ID_W-1:0]        bd_rdata,
  input  logic [CL_AW-1:0]                 cl_addr,
  input  logic [piac_pkg::CNT_W-1:0]       cl_wcount,
  input  logic [piac_pkg::TOT_W-1:0]       cl_wtotal,
  output logic [piac_pkg::CNT_W-1:0]       cl_rcount,
  output logic [piac_pkg::TOT_W-1:0]       cl_rtotal
);

  logic [piac_pkg::TYPE_W-1:0] et_mem [ET_DEPTH];
  logic [piac_pkg::ID_W-1:0]   bd_mem [BD_DEPTH];
  logic [piac_pkg::CNT_W-1:0]  cnt_mem [CL_DEPTH];
  logic [piac_pkg::TOT_W-1:0]  tot_mem [CL_DEPTH];
  logic [CL_DEPTH-1:0]         cl_vld_r;

  always_ff @(posedge clk) begin
    if (req.et_we) begin
      et_mem[et_addr] <= et_wdata;
    end
    if (req.et_re) begin
      et_rdata <= et_mem[et_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.bd_we) begin
      bd_mem[bd_addr] <= bd_wdata;
    end
    if (req.bd_re) begin
      bd_rdata <= bd_mem[bd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.cl_we) begin
      cnt_mem[cl_addr] <= cl_wcount;
      tot_mem[cl_addr] <= cl_wtotal;
    end
    if (req.cl_re) begin
      cl_rcount <= cl_vld_r[cl_addr] ? cnt_mem[cl_addr] : '0;
      cl_rtotal <= cl_vld_r[cl_addr] ? tot_mem[cl_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_vld_r <= '0;
    end else if (req.cl_we) begin
      cl_vld_r[cl_addr] <= 1'b1;
    end
  end

endmodule

/* design/path_in_area_check.sv */
// ----------------------------------------------------------------------------
// Path-in-area check
// Loads element types and sorted border lists per dimension and class, then
// checks path elements against them with one shared id comparator.
// ----------------------------------------------------------------------------
// Load words are written in the idle state. A skipped or out-of-range path
// element goes straight to the done step; a checked one reads its type, its
// list count and first id, then scans up to count-1 more ids, as the border
// port delivers one id per cycle. After reset the element-type memory is
// cleared one per cycle (MAX_DIMS*MAX_ELEMS, 16384 by default), in_stall high.
module path_in_area_check #(
  parameter int MAX_DIMS   = piac_pkg::MAX_DIMS_DEF,
  parameter int MAX_ELEMS  = piac_pkg::MAX_ELEMS_DEF,
  parameter int MAX_BORDER = piac_pkg::MAX_BORDER_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [piac_pkg::FUNC_W-1:0]      in_func,
  input  logic [piac_pkg::DIM_W-1:0]       in_dim,
  input  logic [piac_pkg::ID_W-1:0]        in_elem_id,
  input  logic [piac_pkg::TYPE_W-1:0]      in_elem_type,
  input  logic                             in_cls,
  input  logic [piac_pkg::SLOT_W-1:0]      in_slot,
  input  logic [piac_pkg::CNT_W-1:0]       in_count,
  input  logic [piac_pkg::TOT_W-1:0]       in_total,
  input  logic                             in_wildcard_req,
  input  logic                             in_base_only,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_in_area
);

  localparam int ET_DEPTH = MAX_DIMS * MAX_ELEMS;
  localparam int ET_AW    = $clog2(ET_DEPTH);
  localparam int BD_DEPTH = MAX_DIMS * 2 * MAX_BORDER;
  localparam int BD_AW    = $clog2(BD_DEPTH);
  localparam int CL_DEPTH = MAX_DIMS * 2;
  localparam int CL_AW    = $clog2(CL_DEPTH);
  localparam int CNT_W    = piac_pkg::CNT_W;
  localparam int TOT_W    = piac_pkg::TOT_W;
  localparam int DIM_W    = piac_pkg::DIM_W;
  localparam int ID_W     = piac_pkg::ID_W;
  localparam int TYPE_W   = piac_pkg::TYPE_W;

  piac_pkg::state_t    state_r, state_nxt;
  logic [ET_AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [DIM_W-1:0]    dim_r, dim_nxt;
  logic [ID_W-1:0]     e_r, e_nxt;
  logic                e_ok_r, e_ok_nxt;
  logic                base_only_r, base_only_nxt;
  logic                last_r, last_nxt;
  logic [CL_AW-1:0]    lst_r, lst_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic                verdict_r, verdict_nxt;
  logic                match_r, match_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_in_area_r, out_in_area_nxt;

  piac_pkg::tbl_req_t  req;
  logic [ET_AW-1:0]    et_addr;
  logic [TYPE_W-1:0]   et_wdata;
  logic [TYPE_W-1:0]   et_rdata;
  logic [BD_AW-1:0]    bd_addr;
  logic [ID_W-1:0]     bd_rdata;
  logic [CL_AW-1:0]    cl_addr;
  logic [CNT_W-1:0]    cl_wcount;
  logic [CNT_W-1:0]    cl_rcount;
  logic [TOT_W-1:0]    cl_rtotal;

  logic                in_dim_ok;
  logic                in_e_ok;
  logic                in_slot_ok;
  logic [ET_AW-1:0]    in_et_addr;
  logic [CL_AW-1:0]    in_lst;
  logic [BD_AW-1:0]    in_bd_addr;
  logic [TYPE_W-1:0]   etype;
  logic                sel_cls;
  logic [CL_AW-1:0]    type_lst;
  logic [BD_AW-1:0]    scan_base;
  logic [CNT_W-1:0]    idx_inc;
  logic                id_eq;
  logic                id_lt;
  logic                match_c;

  assign in_dim_ok  = 32'(in_dim) < MAX_DIMS;
  assign in_e_ok    = 32'(in_elem_id) < MAX_ELEMS;
  assign in_slot_ok = 32'(in_slot) < MAX_BORDER;
  assign in_et_addr = ET_AW'(in_dim) * ET_AW'(MAX_ELEMS) + ET_AW'(in_elem_id);
  assign in_lst     = CL_AW'({in_dim, in_cls});
  assign in_bd_addr = BD_AW'(in_lst) * BD_AW'(MAX_BORDER) + BD_AW'(in_slot);
  assign cl_wcount  = (32'(in_count) > MAX_BORDER) ? CNT_W'(MAX_BORDER) : in_count;

  assign etype     = e_ok_r ? et_rdata : '0;
  assign sel_cls   = base_only_r || (etype != piac_pkg::TYPE_CONS);
  assign type_lst  = CL_AW'({dim_r, sel_cls});
  assign scan_base = BD_AW'(lst_r) * BD_AW'(MAX_BORDER);
  assign idx_inc   = idx_r + CNT_W'(1);

  // Shared comparator: path element against the id read from the border list.
  assign id_eq = (e_r == bd_rdata);
  assign id_lt = (e_r < bd_rdata);

  assign match_c = match_r && verdict_r;

  piac_tables #(
    .MAX_DIMS   (MAX_DIMS),
    .MAX_ELEMS  (MAX_ELEMS),
    .MAX_BORDER (MAX_BORDER)
  ) u_tables (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .et_addr   (et_addr),
    .et_wdata  (et_wdata),
    .et_rdata  (et_rdata),
    .bd_addr   (bd_addr),
    .bd_wdata  (in_elem_id),
    .bd_rdata  (bd_rdata),
    .cl_addr   (cl_addr),
    .cl_wcount (cl_wcount),
    .cl_wtotal (in_total),
    .cl_rcount (cl_rcount),
    .cl_rtotal (cl_rtotal)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= piac_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      match_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dim_r         <= dim_nxt;
    e_r           <= e_nxt;
    e_ok_r        <= e_ok_nxt;
    base_only_r   <= base_only_nxt;
    last_r        <= last_nxt;
    lst_r         <= lst_nxt;
    idx_r         <= idx_nxt;
    n_r           <= n_nxt;
    verdict_r     <= verdict_nxt;
    out_in_area_r <= out_in_area_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    dim_nxt         = dim_r;
    e_nxt           = e_r;
    e_ok_nxt        = e_ok_r;
    base_only_nxt   = base_only_r;
    last_nxt        = last_r;
    lst_nxt         = lst_r;
    idx_nxt         = idx_r;
    n_nxt           = n_r;
    verdict_nxt     = verdict_r;
    match_nxt       = match_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_in_area_nxt = out_in_area_r;
    req             = '0;
    et_addr         = in_et_addr;
    et_wdata        = in_elem_type;
    bd_addr         = in_bd_addr;
    cl_addr         = in_lst;

    case (state_r)
      piac_pkg::ST_CLEAR: begin
        req.et_we = 1'b1;
        et_addr   = clr_addr_r;
        et_wdata  = '0;
        if (clr_addr_r == ET_AW'(ET_DEPTH - 1)) begin
          state_nxt = piac_pkg::ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ET_AW'(1);
        end
      end
      piac_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (piac_pkg::func_t'(in_func))
            piac_pkg::FN_SET_TYPE: begin
              req.et_we = in_dim_ok && in_e_ok;
            end
            piac_pkg::FN_SET_BORDER: begin
              req.bd_we = in_dim_ok && in_slot_ok;
            end
            piac_pkg::FN_SET_COUNT: begin
              req.cl_we = in_dim_ok;
            end
            piac_pkg::FN_QUERY: begin
              dim_nxt       = in_dim;
              e_nxt         = in_elem_id;
              e_ok_nxt      = in_e_ok;
              base_only_nxt = in_base_only;
              last_nxt      = in_last;
              if (in_wildcard_req && !in_base_only) begin
                verdict_nxt = 1'b1;
                state_nxt   = piac_pkg::ST_DONE;
              end else if (!in_dim_ok) begin
                verdict_nxt = 1'b0;
                state_nxt   = piac_pkg::ST_DONE;
              end else begin
                req.et_re = 1'b1;
                state_nxt = piac_pkg::ST_TYPE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      piac_pkg::ST_TYPE: begin
        req.cl_re = 1'b1;
        req.bd_re = 1'b1;
        cl_addr   = type_lst;
        bd_addr   = BD_AW'(type_lst) * BD_AW'(MAX_BORDER);
        lst_nxt   = type_lst;
        state_nxt = piac_pkg::ST_COUNT;
      end
      piac_pkg::ST_COUNT: begin
        n_nxt     = cl_rcount;
        state_nxt = piac_pkg::ST_DONE;
        if (cl_rcount == '0) begin
          verdict_nxt = 1'b0;
        end else if (cl_rcount == CNT_W'(1) && !id_eq) begin
          verdict_nxt = 1'b0;
        end else if (TOT_W'(cl_rcount) >= cl_rtotal) begin
          verdict_nxt = 1'b1;
        end else if (id_eq) begin
          verdict_nxt = 1'b1;
        end else if (id_lt) begin
          verdict_nxt = 1'b0;
        end else begin
          req.bd_re = 1'b1;
          bd_addr   = scan_base + BD_AW'(1);
          idx_nxt   = CNT_W'(1);
          state_nxt = piac_pkg::ST_SCAN;
        end
      end
      piac_pkg::ST_SCAN: begin
        if (id_eq) begin
          verdict_nxt = 1'b1;
          state_nxt   = piac_pkg::ST_DONE;
        end else if (id_lt || idx_inc == n_r) begin
          verdict_nxt = 1'b0;
          state_nxt   = piac_pkg::ST_DONE;
        end else begin
          req.bd_re = 1'b1;
          bd_addr   = scan_base + BD_AW'(idx_inc);
          idx_nxt   = idx_inc;
        end
      end
      piac_pkg::ST_DONE: begin
        if (!last_r) begin
          match_nxt = match_c;
          state_nxt = piac_pkg::ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_in_area_nxt = match_c;
          match_nxt       = 1'b1;
          state_nxt       = piac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = piac_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall    = (state_r != piac_pkg::ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_in_area = out_in_area_r;

  // A new result word is only loaded when a path check completes.
  a_out_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == piac_pkg::ST_DONE))
    else $error("result word loaded outside the completion step");

  // No result can appear while the type memory is still being cleared.
  a_no_out_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == piac_pkg::ST_CLEAR |-> !out_valid_r)
    else $error("result word during the clearing pass");

  // The scan index never runs past the list length.
  a_scan_bound : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == piac_pkg::ST_SCAN |-> (idx_r < n_r))
    else $error("border scan index beyond list length");

  // A loaded result word that is stalled keeps its value.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_in_area_r))
    else $error("stalled result word changed");

endmodule
